// ===== hw/rtl/bfq_pkg.sv =====
package bfq_pkg;

    localparam int LANES_MAX = 8;
    localparam int BF16_W    = 16;
    localparam int MAG_W     = 15;
    localparam int CODE_W    = 8;
    localparam int IN_W      = LANES_MAX * BF16_W;
    localparam int OUT_W     = CODE_W * (LANES_MAX + 1);

    localparam logic [MAG_W-1:0]  MAG_INF   = 15'h7F80;
    localparam logic [CODE_W-1:0] CODE_SAT  = 8'h7E;
    localparam logic [CODE_W-1:0] SCALE_INF = 8'd254;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_ENCODE  = 1'b1;
    localparam logic KIND_SCALE = 1'b0;
    localparam logic KIND_CODES = 1'b1;

    // E8M0 code of the least e with peak <= 448 * 2^e, clamped at the bottom.
    // Normal peak: e = ex - 134 - (mantissa <= 96), so code = ex - 7 - that bit.
    function automatic logic [CODE_W-1:0] peak_to_scale(input logic [MAG_W-1:0] mag);
        logic       k;
        logic [9:0] diff;
        k    = (mag[6:0] <= 7'd96);
        diff = {2'b00, mag[14:7]} - 10'd7 - {9'd0, k};
        if (mag == '0) begin
            peak_to_scale = '0;
        end else if (mag >= MAG_INF) begin
            peak_to_scale = SCALE_INF;
        end else if (diff[9]) begin
            peak_to_scale = '0;
        end else begin
            peak_to_scale = diff[7:0];
        end
    endfunction

endpackage

// ===== hw/rtl/bf16_to_fp8_block_quantizer.sv =====
// BF16 to E4M3 block quantizer with a shared E8M0 scale. Send the block's
// measure beats (tuser 0, tlast on the final one), then its encode beats
// (tuser 1). One beat is taken every cycle while results drain; a result
// passes the input and output registers in turn. The lane maxima merge in a
// compare tree on the input side, the running peak folds in with one 15-bit
// compare in the second stage, and encode beats run through LANES parallel
// rounding lanes in that same stage, so a closing beat's scale is used by an
// encode beat that follows directly. Only closing measure beats and encode
// beats produce output.
module bf16_to_fp8_block_quantizer import bfq_pkg::*; #(
    parameter int LANES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // value_0 .. value_7, 16 bits each
    input  logic             s_axis_tlast,   // last
    input  logic             s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // scale_code, code_0 .. code_7
    output logic             m_axis_tuser    // kind
);

    logic                            r_s1_valid;
    logic                            r_s1_op;
    logic                            r_s1_last;
    logic [MAG_W-1:0]                r_s1_imax;
    logic [IN_W-1:0]                 r_s1_data;
    logic [MAG_W-1:0]                r_peak;
    logic [CODE_W-1:0]               r_scale;
    logic                            r_out_valid;
    logic                            r_out_kind;
    logic [OUT_W-1:0]                r_out_data;
    logic [MAG_W-1:0]                n_peak;
    logic [CODE_W-1:0]               n_scale;
    logic [MAG_W-1:0]                w_imax;
    logic                            w_res;
    logic                            w_adv;
    logic [LANES_MAX-1:0][CODE_W-1:0] w_codes;

    bfq_merge #(
        .LANES(LANES)
    ) u_merge (
        .i_value(s_axis_tdata),
        .o_peak (w_imax)
    );

    for (genvar g = 0; g < LANES_MAX; g++) begin : g_lane
        if (g < LANES) begin : g_on
            bfq_lane u_lane (
                .i_raw  (r_s1_data[g*BF16_W +: BF16_W]),
                .i_scale(r_scale),
                .o_code (w_codes[g])
            );
        end else begin : g_off
            assign w_codes[g] = '0;
        end
    end

    assign w_res  = (r_s1_op == OP_ENCODE) || r_s1_last;
    assign w_adv  = r_s1_valid && (!w_res || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_adv;

    assign n_peak  = (r_s1_imax > r_peak) ? r_s1_imax : r_peak;
    assign n_scale = peak_to_scale(n_peak);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s1_op   <= s_axis_tuser;
            r_s1_last <= s_axis_tlast;
            r_s1_imax <= w_imax;
            r_s1_data <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_scale <= '0;
        end else if (w_adv && r_s1_op == OP_MEASURE) begin
            if (r_s1_last) begin
                r_peak  <= '0;
                r_scale <= n_scale;
            end else begin
                r_peak <= n_peak;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_res) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res) begin
            if (r_s1_op == OP_ENCODE) begin
                r_out_kind <= KIND_CODES;
                r_out_data <= {w_codes, r_scale};
            end else begin
                r_out_kind <= KIND_SCALE;
                r_out_data <= {{(OUT_W-CODE_W){1'b0}}, n_scale};
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = r_out_data;

    a_scale_beat_no_codes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_SCALE) |-> (m_axis_tdata[OUT_W-1:CODE_W] == '0))
        else $error("scale beat carries nonzero codes");

    a_peak_cleared : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s1_op == OP_MEASURE && r_s1_last) |=> (r_peak == '0))
        else $error("peak not cleared after block close");

    a_codes_use_scale : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_CODES) |-> (m_axis_tdata[CODE_W-1:0] == r_scale))
        else $error("codes beat scale differs from block scale");

    a_scale_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[CODE_W-1:0] != 8'hFF))
        else $error("scale code out of range");

endmodule

// ===== hw/rtl/bfq_lane.sv =====
module bfq_lane import bfq_pkg::*; (
    input  logic [BF16_W-1:0] i_raw,
    input  logic [CODE_W-1:0] i_scale,
    output logic [CODE_W-1:0] o_code
);

    logic              w_neg;
    logic [MAG_W-1:0]  w_mag;
    logic [7:0]        w_ex;
    logic [6:0]        w_man;
    logic [2:0]        w_lz;
    logic [7:0]        w_mn;
    logic signed [9:0] w_ee;
    logic signed [9:0] w_p;
    logic signed [9:0] w_pb;
    logic [4:0]        w_n;
    logic [7:0]        w_sum;
    logic [6:0]        w_mcode;

    assign w_neg = i_raw[15];
    assign w_mag = i_raw[MAG_W-1:0];
    assign w_ex  = w_mag[14:7];
    assign w_man = w_mag[6:0];

    // normalize the significand so its leading one sits at bit 7
    always_comb begin
        w_lz = 3'd7;
        for (int i = 0; i < 7; i++) begin
            if (w_man[i]) begin
                w_lz = 3'(7 - i);
            end
        end
        if (w_ex != '0) begin
            w_mn = {1'b1, w_man};
            w_ee = $signed({2'b00, w_ex});
        end else begin
            w_mn = 8'({1'b0, w_man} << w_lz);
            w_ee = 10'sd1 - $signed({7'd0, w_lz});
        end
        w_p  = w_ee - $signed({2'b00, i_scale});
        w_pb = w_p + 10'sd6;
    end

    // round half toward smaller magnitude
    always_comb begin
        w_n     = '0;
        w_sum   = '0;
        w_mcode = '0;
        if (w_p > 10'sd8) begin
            w_mcode = CODE_SAT[6:0];
        end else if (w_p >= -10'sd6) begin
            w_n   = {1'b0, w_mn[7:4]} + {4'd0, (w_mn[3:0] > 4'd8)};
            w_sum = {1'b0, w_pb[3:0], 3'b000} + {3'd0, w_n};
            if (w_sum > {1'b0, CODE_SAT[6:0]}) begin
                w_mcode = CODE_SAT[6:0];
            end else begin
                w_mcode = w_sum[6:0];
            end
        end else begin
            case (w_p)
                -10'sd7:  w_n = {2'd0, w_mn[7:5]} + {4'd0, (w_mn[4:0] > 5'd16)};
                -10'sd8:  w_n = {3'd0, w_mn[7:6]} + {4'd0, (w_mn[5:0] > 6'd32)};
                -10'sd9:  w_n = {4'd0, w_mn[7]} + {4'd0, (w_mn[6:0] > 7'd64)};
                -10'sd10: w_n = {4'd0, (w_mn > 8'd128)};
                default:  w_n = '0;
            endcase
            w_mcode = {2'b00, w_n};
        end
    end

    always_comb begin
        if (w_mag > MAG_INF) begin
            o_code = CODE_SAT;
        end else if (w_mag == '0) begin
            o_code = '0;
        end else if (w_mag == MAG_INF) begin
            o_code = {w_neg, CODE_SAT[6:0]};
        end else begin
            o_code = {w_neg & (w_mcode != '0), w_mcode};
        end
    end

endmodule

// ===== hw/rtl/bfq_merge.sv =====
module bfq_merge import bfq_pkg::*; #(
    parameter int LANES = 8
) (
    input  logic [LANES_MAX-1:0][BF16_W-1:0] i_value,
    output logic [MAG_W-1:0]                 o_peak
);

    logic [LANES_MAX-1:0][MAG_W-1:0] w_mag;
    logic [3:0][MAG_W-1:0]           w_l1;
    logic [1:0][MAG_W-1:0]           w_l2;

    // NaN lanes and unused lanes drop out as zero
    always_comb begin
        for (int i = 0; i < LANES_MAX; i++) begin
            if (i < LANES && i_value[i][MAG_W-1:0] <= MAG_INF) begin
                w_mag[i] = i_value[i][MAG_W-1:0];
            end else begin
                w_mag[i] = '0;
            end
        end
        for (int i = 0; i < 4; i++) begin
            w_l1[i] = (w_mag[2*i] > w_mag[2*i+1]) ? w_mag[2*i] : w_mag[2*i+1];
        end
        for (int i = 0; i < 2; i++) begin
            w_l2[i] = (w_l1[2*i] > w_l1[2*i+1]) ? w_l1[2*i] : w_l1[2*i+1];
        end
        o_peak = (w_l2[0] > w_l2[1]) ? w_l2[0] : w_l2[1];
    end

endmodule
